@@ rtl/bhsw_pkg.sv @@
package bhsw_pkg;

    localparam logic [9:0] LINE_PIXELS   = 10'd512;
    localparam logic [7:0] FULL_MASK     = 8'hff;
    localparam logic [6:0] BPR_RESET     = 7'd40;

    typedef struct packed {
        logic [8:0] x_start;
        logic [7:0] y_row;
        logic [9:0] length;
        logic       color;
    } t_in_item;

    typedef struct packed {
        logic [13:0] byte_offset;
        logic [7:0]  pixel_mask;
        logic        set_bits;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic at_last;
        logic out_free;
    } t_status;

endpackage

@@ rtl/bhsw_ctrl.sv @@
module bhsw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bhsw_pkg::t_status i_status,
    output logic              o_in_stall,
    output bhsw_pkg::t_cmd    o_cmd
);

    bhsw_pkg::t_state r_state;
    bhsw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhsw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bhsw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bhsw_pkg::ST_SETUP;
                end
            end
            bhsw_pkg::ST_SETUP: begin
                n_state = i_status.empty ? bhsw_pkg::ST_IDLE : bhsw_pkg::ST_RUN;
            end
            bhsw_pkg::ST_RUN: begin
                if (i_status.out_free && i_status.at_last) begin
                    n_state = bhsw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bhsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            bhsw_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            bhsw_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            bhsw_pkg::ST_RUN: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/bhsw_dp.sv @@
module bhsw_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bhsw_pkg::t_in_item  i_in_data,
    input  logic                i_cfg_valid,
    input  logic [6:0]          i_cfg_data,
    input  logic                i_out_stall,
    input  bhsw_pkg::t_cmd      i_cmd,
    output bhsw_pkg::t_status   o_status,
    output logic                o_out_valid,
    output bhsw_pkg::t_out_item o_out_data
);

    logic [6:0]          r_bpr;
    bhsw_pkg::t_in_item  r_item;
    logic [13:0]         r_base;
    logic [5:0]          r_col;
    logic [5:0]          r_last_col;
    logic [2:0]          r_end_lo;
    logic                r_first;
    logic                r_out_valid;
    bhsw_pkg::t_out_item r_out;

    logic [9:0]  rem_px;
    logic [9:0]  len_clip;
    logic [9:0]  end_px;
    logic [14:0] row_prod;
    logic [13:0] n_base;
    logic        at_last;
    logic [7:0]  mask;
    logic [8:0]  col_off;

    assign rem_px   = bhsw_pkg::LINE_PIXELS - {1'b0, r_item.x_start};
    assign len_clip = (r_item.length > rem_px) ? rem_px : r_item.length;
    assign end_px   = {1'b0, r_item.x_start} + len_clip - 10'd1;
    assign row_prod = {8'b0, r_bpr} * {7'b0, r_item.y_row[7:3], 3'b000};
    assign n_base   = row_prod[13:0] + {11'b0, r_item.y_row[2:0]};

    assign at_last  = (r_col == r_last_col);
    assign col_off  = {r_col, 3'b000};

    always_comb begin
        mask = bhsw_pkg::FULL_MASK;
        if (r_first) begin
            mask = mask & (bhsw_pkg::FULL_MASK >> r_item.x_start[2:0]);
        end
        if (at_last) begin
            mask = mask & (bhsw_pkg::FULL_MASK << (3'd7 - r_end_lo));
        end
    end

    assign o_status.empty    = (len_clip == 10'd0);
    assign o_status.at_last  = at_last;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpr       <= bhsw_pkg::BPR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bpr <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.setup) begin
            r_base     <= n_base;
            r_col      <= r_item.x_start[8:3];
            r_last_col <= end_px[8:3];
            r_end_lo   <= end_px[2:0];
            r_first    <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_out.byte_offset <= r_base + {5'b0, col_off};
            r_out.pixel_mask  <= mask;
            r_out.set_bits    <= r_item.color;
            r_out.last        <= at_last;
            r_col             <= r_col + 6'd1;
            r_first           <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/bitmap_hline_span_writer_core.sv @@
// Horizontal line writer for a 1-bit bitmap stored as 8x8 character cells.
// A line request transfers on the input channel when i_in_valid is high and
// o_in_stall is low. Each request yields one masked byte write per byte
// column it covers, left to right, on the output channel; a write transfers
// when o_out_valid is high and i_out_stall is low, and the final write of a
// line has last set. A request of zero length, after clipping at pixel 512,
// yields no writes.
// The request is registered in the idle state; the setup state then computes
// the clipped span and the cell row address with a single 7x8 multiply.
// After that the byte column counter issues one write per cycle while the
// receiver does not stall. A new request is taken once the last write of the
// previous line sits in the output register.
// While the receiver stalls, the output register holds its write and the
// column counter waits. The bytes_per_row register is written through the
// configuration channel, which is always ready, and should change only while
// the block is idle. Reset clears the control state and sets bytes_per_row
// to 40.
module bitmap_hline_span_writer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bhsw_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bhsw_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [6:0]          i_cfg_data
);

    bhsw_pkg::t_cmd    cmd;
    bhsw_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    bhsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    bhsw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/tb.sv @@
module tb;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    bhsw_pkg::t_in_item    i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    bhsw_pkg::t_out_item   o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [6:0]            i_cfg_data = '0;

    bhsw_pkg::t_out_item   expected_writes[$];
    logic [6:0]  row_bytes = bhsw_pkg::BPR_RESET;
    int          lines_sent = 0;
    int          writes_checked = 0;
    int          error_count = 0;
    int          widths_used = 1;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    bitmap_hline_span_writer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            return $urandom_range(1, 3);
        end else if (r < 19) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic void predict_span_writes(bhsw_pkg::t_in_item line);
        int unsigned x, y, len, stop, col, first_col, last_col, base;
        logic [7:0]  mask;
        bhsw_pkg::t_out_item w;
        x = 32'(line.x_start);
        y = 32'(line.y_row);
        len = 32'(line.length);
        if (len > bhsw_pkg::LINE_PIXELS - x) begin
            len = bhsw_pkg::LINE_PIXELS - x;
        end
        if (len == 0) begin
            return;
        end
        stop = x + len - 1;
        first_col = x >> 3;
        last_col = stop >> 3;
        base = row_bytes * (y & 'hf8) + (y & 'h7);
        for (col = first_col; col <= last_col; col++) begin
            mask = bhsw_pkg::FULL_MASK;
            if (col == first_col) begin
                mask &= bhsw_pkg::FULL_MASK >> (x % 8);
            end
            if (col == last_col) begin
                mask &= bhsw_pkg::FULL_MASK << (7 - stop % 8);
            end
            w.byte_offset = 14'(base + col * 8);
            w.pixel_mask = mask;
            w.set_bits = line.color;
            w.last = (col == last_col);
            expected_writes.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch in %s: got 0x%0h, expected 0x%0h (write %0d)",
                 what, got, want, writes_checked);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        bhsw_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_writes.size() == 0) begin
                report_mismatch("unexpected write offset", o_out_data.byte_offset, 0);
            end else begin
                want = expected_writes.pop_front();
                if (o_out_data.byte_offset !== want.byte_offset)
                    report_mismatch("byte_offset", o_out_data.byte_offset, want.byte_offset);
                if (o_out_data.pixel_mask !== want.pixel_mask)
                    report_mismatch("pixel_mask", o_out_data.pixel_mask, want.pixel_mask);
                if (o_out_data.set_bits !== want.set_bits)
                    report_mismatch("set_bits", o_out_data.set_bits, want.set_bits);
                if (o_out_data.last !== want.last)
                    report_mismatch("last", o_out_data.last, want.last);
            end
            writes_checked++;
        end
    end

    // The receiver stalls at random, and on request holds off for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_idle_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_line(input int x, input int y, input int len, input int color);
        bhsw_pkg::t_in_item line;
        int       gap;
        line.x_start = 9'(x);
        line.y_row = 8'(y);
        line.length = 10'(len);
        line.color = 1'(color);
        gap = (gaps_on && $urandom_range(0, 1)) ? pick_idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= line;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_span_writes(line);
        lines_sent++;
    endtask

    task automatic send_random_line();
        int r, len;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            len = $urandom_range(0, 16);
        end else if (r < 9) begin
            len = $urandom_range(0, 80);
        end else begin
            len = $urandom_range(0, 1023);
        end
        send_line($urandom_range(0, 511), $urandom_range(0, 255), len, $urandom_range(0, 1));
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_row_bytes(input logic [6:0] value);
        wait_for_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        row_bytes = value;
        widths_used++;
    endtask

    task automatic test_directed_spans();
        send_line(0, 0, 0, 1);
        send_line(0, 0, 1, 1);
        send_line(0, 0, 8, 1);
        send_line(3, 5, 3, 0);
        send_line(1, 3, 7, 1);
        send_line(7, 9, 2, 0);
        send_line(6, 250, 10, 1);
        send_line(511, 255, 1, 1);
        send_line(511, 255, 512, 0);
        send_line(504, 8, 8, 1);
        send_line(0, 0, 512, 1);
        send_line(100, 7, 1023, 1);
        send_line(256, 128, 256, 0);
        send_line(500, 200, 0, 0);
    endtask

    task automatic test_row_width_extremes();
        logic [6:0] widths[4] = '{7'd0, 7'd1, 7'd64, 7'd127};
        foreach (widths[i]) begin
            write_row_bytes(widths[i]);
            send_line(0, 255, 512, 1);
            send_line(509, 248, 3, 0);
            send_random_line();
        end
        write_row_bytes(bhsw_pkg::BPR_RESET);
    endtask

    task automatic test_back_pressure();
        gaps_on = 1'b0;
        hold_reqs++;
        repeat (12) begin
            send_line($urandom_range(0, 200), $urandom_range(0, 255),
                      $urandom_range(40, 300), $urandom_range(0, 1));
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random_spans();
        logic [6:0] widths[5];
        widths = '{7'd64, 7'd1, 7'd0, 7'd127, 7'($urandom_range(0, 127))};
        foreach (widths[i]) begin
            write_row_bytes(widths[i]);
            gaps_on = (i != 1);
            stalls_on = (i != 2);
            repeat (74) send_random_line();
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_spans();
        test_row_width_extremes();
        test_back_pressure();
        test_random_spans();
        wait_for_drain();
        $display("Sent %0d line requests and checked %0d byte writes over %0d row width settings,",
                 lines_sent, writes_checked, widths_used);
        $display("with clipped, single-byte and empty lines, random gaps and long back pressure.");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Timed out with %0d byte writes still expected.", expected_writes.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bhsw_pkg.sv
rtl/bhsw_ctrl.sv
rtl/bhsw_dp.sv
rtl/bitmap_hline_span_writer_core.sv
tb/tb.sv
